// ===== design/bda_pkg.sv =====
// -----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the button debounce / auto-repeat block.
// -----------------------------------------------------------------------------
package bda_pkg;

   // Field widths
   localparam int LEVEL_BITS = 4;   // pressed-level bits in one item
   localparam int TIME_W     = 32;  // millisecond timestamp
   localparam int CFG_W      = 16;  // time registers
   localparam int KEY_W      = 3;   // key_event code
   localparam int CSR_IDX_W  = 2;   // register index

   // Default number of buttons
   localparam int NUM_BUTTONS_DEF = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RPT_DELAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RPT_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RPT_ENABLE  = 2'd3;

   // Register reset values
   localparam logic [CFG_W-1:0]      DEBOUNCE_RST     = 16'd30;
   localparam logic [CFG_W-1:0]      RPT_DELAY_RST    = 16'd400;
   localparam logic [CFG_W-1:0]      RPT_INTERVAL_RST = 16'd80;
   localparam logic [LEVEL_BITS-1:0] RPT_ENABLE_RST   = 4'd3;

   // Key code meaning "no event"
   localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;

   // Timing settings shared by all lanes
   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] repeat_delay_ms;
      logic [CFG_W-1:0] repeat_interval_ms;
   } bda_cfg_type;

   // Per-lane status toward the merge stage
   typedef struct packed {
      logic fire;       // lane gives a press or repeat event on this item
      logic held_next;  // held mark after this item
   } bda_lane_stat_type;

endpackage

// ===== design/bda_lane.sv =====
// -----------------------------------------------------------------------------
// bda_lane
// One button: settle timer, held mark and repeat timers. Evaluates the item
// in parallel with the other lanes and updates only when commit is high.
// -----------------------------------------------------------------------------
module bda_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  bda_pkg::bda_cfg_type         cfg,
   input  logic                         rpt_en,
   input  logic                         level,
   input  logic [bda_pkg::TIME_W-1:0]   now_ms,
   input  logic                         commit,
   output bda_pkg::bda_lane_stat_type   stat
);
   import bda_pkg::*;

   logic              last_level_ff, last_level_in;
   logic              held_ff, held_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] press_time_ff, press_time_in;
   logic [TIME_W-1:0] rpt_time_ff, rpt_time_in;

   logic              changed, settled, stable_ok;
   logic              press_ev, release_ev, repeat_ev;
   logic [TIME_W-1:0] since_change, since_press, since_rpt;

   // Elapsed times, wrapping modulo 2^32
   assign since_change = now_ms - change_time_ff;
   assign since_press  = now_ms - press_time_ff;
   assign since_rpt    = now_ms - rpt_time_ff;

   // Event decode
   assign changed    = (level != last_level_ff);
   assign settled    = (since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
   assign stable_ok  = !changed && settled;
   assign press_ev   = stable_ok && level && !held_ff;
   assign release_ev = stable_ok && !level && held_ff;
   assign repeat_ev  = stable_ok && level && held_ff && rpt_en
                    && (since_press > {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_delay_ms})
                    && (since_rpt > {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_interval_ms});

   // Next state, applied only for committed lanes
   always_comb begin
      last_level_in  = last_level_ff;
      held_in        = held_ff;
      change_time_in = change_time_ff;
      press_time_in  = press_time_ff;
      rpt_time_in    = rpt_time_ff;
      if (commit) begin
         if (changed) begin
            last_level_in  = level;
            change_time_in = now_ms;
         end
         if (press_ev) begin
            held_in       = 1'b1;
            press_time_in = now_ms;
            rpt_time_in   = now_ms;
         end
         if (release_ev) begin
            held_in = 1'b0;
         end
         if (repeat_ev) begin
            rpt_time_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b0;
         held_ff        <= 1'b0;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         rpt_time_ff    <= '0;
      end else begin
         last_level_ff  <= last_level_in;
         held_ff        <= held_in;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
         rpt_time_ff    <= rpt_time_in;
      end
   end

   assign stat.fire      = press_ev || repeat_ev;
   assign stat.held_next = held_in;

endmodule

// ===== design/bda_merge.sv =====
// -----------------------------------------------------------------------------
// bda_merge
// Priority merge of the lanes: the first firing lane gives the key, lanes
// after it are not sampled on this item, and the held marks are ORed.
// -----------------------------------------------------------------------------
module bda_merge #(
   parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF
) (
   input  logic                       accept,
   input  bda_pkg::bda_lane_stat_type stat [NUM_BUTTONS],
   output logic [NUM_BUTTONS-1:0]     commit,
   output logic [bda_pkg::KEY_W-1:0]  key_event,
   output logic                       any_held
);
   import bda_pkg::*;

   logic [NUM_BUTTONS:0] fired_before;

   // Lane i is sampled when no earlier lane fired
   always_comb begin
      fired_before[0] = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         fired_before[i+1] = fired_before[i] || stat[i].fire;
         commit[i]         = accept && !fired_before[i];
      end
   end

   // Key of the first firing lane, masked to the field width
   always_comb begin
      key_event = KEY_NONE;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (stat[i].fire) begin
            key_event = KEY_W'(i + 1);
         end
      end
   end

   // Held flag after this item's updates
   always_comb begin
      any_held = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         any_held = any_held || stat[i].held_next;
      end
   end

endmodule

// ===== design/button_debounce_autorepeat.sv =====
// -----------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounce of up to four buttons with press and auto-repeat events.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-----------------------------------------
//   req     | req_valid/req_stall| req_pressed_levels[3:0], req_now_ms[31:0]
//   rsp     | rsp_valid/rsp_stall| rsp_key_event[2:0], rsp_any_held
//   csr     | csr_valid/csr_ready| csr_index[1:0], csr_wdata[15:0]
//
// One item per cycle while req_stall is low; rsp outputs are registered.
// All button lanes evaluate the item at once and a priority merge decides
// which lanes update; the lane state is written in the accepting cycle.
// A two-entry output buffer (output register plus skid) lets req keep
// flowing while one result waits; req_stall rises only when both are full.
// Reset (synchronous) clears lane state, buffers and registers to defaults.
// -----------------------------------------------------------------------------
module button_debounce_autorepeat #(
   parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // item input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bda_pkg::LEVEL_BITS-1:0]    req_pressed_levels,
   input  logic [bda_pkg::TIME_W-1:0]        req_now_ms,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bda_pkg::KEY_W-1:0]         rsp_key_event,
   output logic                              rsp_any_held,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bda_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bda_pkg::CFG_W-1:0]         csr_wdata
);
   import bda_pkg::*;

   // Configuration registers
   bda_cfg_type           cfg_ff;
   logic [LEVEL_BITS-1:0] rpt_mask_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= DEBOUNCE_RST;
         cfg_ff.repeat_delay_ms    <= RPT_DELAY_RST;
         cfg_ff.repeat_interval_ms <= RPT_INTERVAL_RST;
         rpt_mask_ff               <= RPT_ENABLE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEBOUNCE:     cfg_ff.debounce_ms        <= csr_wdata;
            REG_RPT_DELAY:    cfg_ff.repeat_delay_ms    <= csr_wdata;
            REG_RPT_INTERVAL: cfg_ff.repeat_interval_ms <= csr_wdata;
            REG_RPT_ENABLE:   rpt_mask_ff               <= csr_wdata[LEVEL_BITS-1:0];
            default:          ;
         endcase
      end
   end

   // Input handshake
   logic skid_valid_ff, skid_valid_in;
   logic accept;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   // Button lanes
   bda_lane_stat_type      stat [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] commit;
   logic [KEY_W-1:0]       key_event;
   logic                   any_held;

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      logic lane_level, lane_en;
      if (g < LEVEL_BITS) begin : g_pin
         assign lane_level = req_pressed_levels[g];
         assign lane_en    = rpt_mask_ff[g];
      end else begin : g_nopin
         assign lane_level = 1'b0;
         assign lane_en    = 1'b0;
      end

      bda_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg_ff),
         .rpt_en (lane_en),
         .level  (lane_level),
         .now_ms (req_now_ms),
         .commit (commit[g]),
         .stat   (stat[g])
      );
   end

   // Merge stage
   bda_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .accept    (accept),
      .stat      (stat),
      .commit    (commit),
      .key_event (key_event),
      .any_held  (any_held)
   );

   // Output register and skid entry
   logic             out_valid_ff, out_valid_in;
   logic [KEY_W-1:0] out_key_ff, out_key_in;
   logic             out_held_ff, out_held_in;
   logic [KEY_W-1:0] skid_key_ff, skid_key_in;
   logic             skid_held_ff, skid_held_in;
   logic             out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff && !out_take;
      out_key_in    = out_key_ff;
      out_held_in   = out_held_ff;
      skid_valid_in = skid_valid_ff;
      skid_key_in   = skid_key_ff;
      skid_held_in  = skid_held_ff;
      if (skid_valid_ff) begin
         // drain skid into the output register
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_key_in    = skid_key_ff;
            out_held_in   = skid_held_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_key_in   = key_event;
            out_held_in  = any_held;
         end else begin
            skid_valid_in = 1'b1;
            skid_key_in   = key_event;
            skid_held_in  = any_held;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_key_ff   <= out_key_in;
      out_held_ff  <= out_held_in;
      skid_key_ff  <= skid_key_in;
      skid_held_ff <= skid_held_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_event = out_key_ff;
   assign rsp_any_held  = out_held_ff;

endmodule

// ===== tb/bda_poll_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bda_poll_checker
// Watches the req, rsp and csr channels of the button debounce block. It keeps
// its own copy of the timing registers and the per-button lane state, works out
// the key event and held flag for every accepted item, and compares each
// accepted result against the oldest outstanding prediction.
// -----------------------------------------------------------------------------
module bda_poll_checker #(
   parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [bda_pkg::LEVEL_BITS-1:0] req_pressed_levels,
   input  logic [bda_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [bda_pkg::KEY_W-1:0]      rsp_key_event,
   input  logic                           rsp_any_held,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bda_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bda_pkg::CFG_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             polls_pending
);
   import bda_pkg::*;

   typedef struct packed {
      logic [KEY_W-1:0] key_event;
      logic             any_held;
   } poll_result_type;

   // Shadow registers
   logic [CFG_W-1:0]      debounce_ms;
   logic [CFG_W-1:0]      repeat_delay_ms;
   logic [CFG_W-1:0]      repeat_interval_ms;
   logic [LEVEL_BITS-1:0] repeat_mask;

   // Shadow lane state
   logic              level_seen [NUM_BUTTONS];
   logic              held       [NUM_BUTTONS];
   logic [TIME_W-1:0] change_ms  [NUM_BUTTONS];
   logic [TIME_W-1:0] press_ms   [NUM_BUTTONS];
   logic [TIME_W-1:0] repeat_ms  [NUM_BUTTONS];

   // Predicted results, oldest first
   poll_result_type key_results_due[$];

   initial fail_count = 0;
   initial polls_pending = 0;

   function automatic void clear_lanes();
      debounce_ms        = DEBOUNCE_RST;
      repeat_delay_ms    = RPT_DELAY_RST;
      repeat_interval_ms = RPT_INTERVAL_RST;
      repeat_mask        = RPT_ENABLE_RST;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         level_seen[b] = 1'b0;
         held[b]       = 1'b0;
         change_ms[b]  = '0;
         press_ms[b]   = '0;
         repeat_ms[b]  = '0;
      end
   endfunction

   // Scan buttons in priority order; the first press or repeat ends the scan.
   function automatic poll_result_type scan_buttons(input logic [LEVEL_BITS-1:0] levels,
                                                    input logic [TIME_W-1:0] now);
      poll_result_type   res;
      logic              lvl;
      logic              rpt_on;
      logic              stop;
      logic [TIME_W-1:0] settle;
      res.key_event = KEY_NONE;
      res.any_held  = 1'b0;
      stop = 1'b0;
      for (int b = 0; b < NUM_BUTTONS && !stop; b++) begin
         lvl    = (b < LEVEL_BITS) ? levels[b] : 1'b0;
         rpt_on = (b < LEVEL_BITS) ? repeat_mask[b] : 1'b0;
         settle = now - change_ms[b];
         if (lvl != level_seen[b]) begin
            // level moved: only record it and restart settling
            level_seen[b] = lvl;
            change_ms[b]  = now;
         end else if (settle >= TIME_W'(debounce_ms)) begin
            if (lvl && !held[b]) begin
               held[b]       = 1'b1;
               press_ms[b]   = now;
               repeat_ms[b]  = now;
               res.key_event = KEY_W'(b + 1);
               stop          = 1'b1;
            end else if (!lvl && held[b]) begin
               held[b] = 1'b0;
            end else if (lvl && held[b] && rpt_on &&
                         TIME_W'(now - press_ms[b]) > TIME_W'(repeat_delay_ms) &&
                         TIME_W'(now - repeat_ms[b]) > TIME_W'(repeat_interval_ms)) begin
               repeat_ms[b]  = now;
               res.key_event = KEY_W'(b + 1);
               stop          = 1'b1;
            end
         end
      end
      for (int b = 0; b < NUM_BUTTONS; b++)
         if (held[b]) res.any_held = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      poll_result_type due;
      if (reset) begin
         clear_lanes();
         key_results_due.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEBOUNCE:     debounce_ms        = csr_wdata;
               REG_RPT_DELAY:    repeat_delay_ms    = csr_wdata;
               REG_RPT_INTERVAL: repeat_interval_ms = csr_wdata;
               REG_RPT_ENABLE:   repeat_mask        = csr_wdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         // result side: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (key_results_due.size() == 0) begin
               $error("unexpected result: key_event %0d any_held %0b",
                      rsp_key_event, rsp_any_held);
               fail_count++;
            end else begin
               due = key_results_due.pop_front();
               if (rsp_key_event !== due.key_event) begin
                  $error("key_event mismatch: expected %0d, actual %0d",
                         due.key_event, rsp_key_event);
                  fail_count++;
               end
               if (rsp_any_held !== due.any_held) begin
                  $error("any_held mismatch: expected %0b, actual %0b",
                         due.any_held, rsp_any_held);
                  fail_count++;
               end
            end
         end
         // item side: predict
         if (req_valid && !req_stall)
            key_results_due.push_back(scan_buttons(req_pressed_levels, req_now_ms));
      end
      polls_pending = key_results_due.size();
   end

endmodule

// ===== tb/tb_button_debounce_autorepeat.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_button_debounce_autorepeat
// Drives polls of button levels and timestamps into the debounce block under
// several timing settings and idle/stall patterns; the poll checker predicts
// and compares every result and reports its failure count for the verdict.
// -----------------------------------------------------------------------------
module tb_button_debounce_autorepeat;
   import bda_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LEVEL_BITS-1:0] req_pressed_levels = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KEY_W-1:0]      rsp_key_event;
   logic                  rsp_any_held;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_DEBOUNCE;
   logic [CFG_W-1:0]      csr_wdata = '0;

   int fail_count;
   int polls_pending;

   // Idle and stall knobs for the current phase
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   bit hold_en = 1'b0;
   int hold_left = 0;
   bit hold_seen = 1'b0;

   logic [TIME_W-1:0] poll_ms = '0;

   button_debounce_autorepeat DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pressed_levels (req_pressed_levels),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_event      (rsp_key_event),
      .rsp_any_held       (rsp_any_held),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   bda_poll_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pressed_levels (req_pressed_levels),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_event      (rsp_key_event),
      .rsp_any_held       (rsp_any_held),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .polls_pending      (polls_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: random stalls, plus long hold-offs when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_en && (!hold_seen || $urandom_range(299) == 0)) begin
         hold_seen <= 1'b1;
         hold_left <= $urandom_range(120, 60);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_poll(input logic [LEVEL_BITS-1:0] lv, input logic [TIME_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_pressed_levels <= lv;
      req_now_ms         <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (polls_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                             input logic [CFG_W-1:0] ivl, input logic [CFG_W-1:0] mask);
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_RPT_DELAY, dly);
      write_reg(REG_RPT_INTERVAL, ivl);
      write_reg(REG_RPT_ENABLE, mask);
      csr_valid <= 1'b0;
   endtask

   // Random polls: mostly held level patterns with some bounce, rest noise
   task automatic poll_run(input int n_polls, input int step_max);
      int                    seg_left;
      int                    bounce_left;
      bit                    noisy;
      logic [LEVEL_BITS-1:0] seg_lv;
      logic [LEVEL_BITS-1:0] lv;
      seg_left    = 0;
      bounce_left = 0;
      noisy       = 1'b0;
      seg_lv      = '0;
      for (int k = 0; k < n_polls; k++) begin
         if (seg_left == 0) begin
            seg_lv      = LEVEL_BITS'($urandom_range(15));
            noisy       = ($urandom_range(99) < 15);
            seg_left    = noisy ? $urandom_range(8, 1) : $urandom_range(80, 1);
            bounce_left = (!noisy && $urandom_range(9) < 4) ? $urandom_range(4, 1) : 0;
         end
         if (noisy) begin
            lv = LEVEL_BITS'($urandom_range(15));
            if ($urandom_range(3) == 0) poll_ms = $urandom;
            else poll_ms = poll_ms + $urandom_range(step_max);
            seg_left--;
         end else if (bounce_left != 0) begin
            lv = seg_lv ^ LEVEL_BITS'($urandom_range(15, 1));
            poll_ms = poll_ms + $urandom_range(step_max);
            bounce_left--;
         end else begin
            lv = seg_lv;
            poll_ms = poll_ms + $urandom_range(step_max);
            seg_left--;
         end
         send_poll(lv, poll_ms);
      end
   endtask

   task automatic random_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                               input logic [CFG_W-1:0] ivl, input logic [CFG_W-1:0] mask,
                               input int step_max, input int s_idle, input int r_stall,
                               input bit hold, input int n_polls);
      set_timing(deb, dly, ivl, mask);
      send_idle_pct = s_idle;
      rcv_stall_pct = r_stall;
      hold_en       = hold;
      poll_run(n_polls, step_max);
      drain();
      hold_en = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default timing, settle, scan order, repeats, release
      send_poll(4'h0, 32'd0);
      send_poll(4'hF, 32'd10);
      send_poll(4'hF, 32'd39);
      send_poll(4'hF, 32'd40);
      send_poll(4'hF, 32'd40);
      send_poll(4'hF, 32'd41);
      send_poll(4'hF, 32'd42);
      send_poll(4'hF, 32'd500);
      send_poll(4'hF, 32'd500);
      send_poll(4'hF, 32'd500);
      send_poll(4'h0, 32'd600);
      send_poll(4'h0, 32'd630);
      // timestamp wrap across the top of the range
      send_poll(4'h1, 32'hFFFF_FFF0);
      send_poll(4'h1, 32'hFFFF_FFFF);
      send_poll(4'h1, 32'h0000_0010);
      send_poll(4'h0, 32'h0000_0040);
      drain();

      // Directed: zero settle and repeat times, mask written with high bits set
      set_timing(16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_poll(4'h4, 32'd1000);
      send_poll(4'h4, 32'd1000);
      send_poll(4'h4, 32'd1000);
      send_poll(4'h4, 32'd1001);
      send_poll(4'h0, 32'd1001);
      send_poll(4'h0, 32'd1001);
      drain();

      // Random phases across timing settings and idle patterns
      random_phase(16'd5, 16'd40, 16'd10, 16'hF, 4, 0, 0, 1'b0, 250);
      random_phase(16'd0, 16'd0, 16'd0, 16'h5, 2, 80, 0, 1'b0, 250);
      random_phase(16'd12, 16'd60, 16'd15, 16'hA, 6, 0, 80, 1'b0, 250);
      random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF, 20000, 15, 15, 1'b0, 200);
      random_phase(16'd3, 16'd25, 16'd5, 16'h0, 3, 0, 0, 1'b1, 250);
      random_phase(CFG_W'($urandom_range(20)), CFG_W'($urandom_range(100)),
                   CFG_W'($urandom_range(30)), CFG_W'($urandom_range(15)),
                   5, 15, 15, 1'b0, 250);
      random_phase(DEBOUNCE_RST, RPT_DELAY_RST, RPT_INTERVAL_RST, CFG_W'(RPT_ENABLE_RST),
                   20, 80, 0, 1'b0, 200);
      random_phase(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                   CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(15)),
                   5000, 0, 80, 1'b0, 200);

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bda_pkg.sv
design/bda_lane.sv
design/bda_merge.sv
design/button_debounce_autorepeat.sv
tb/bda_poll_checker.sv
tb/tb_button_debounce_autorepeat.sv
